[rtl/assert_macros.svh]
// Assertion macros shared by the MAC unit and the top level of the IMU frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion that is switched off while reset is asserted.
`define IFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");
// Clocked assertion that is checked during reset as well.
`define IFP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("%m: assertion failed");
`else
`define IFP_ASSERT(lbl, prop)
`define IFP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[rtl/ifp_pkg.sv]
// Shared types and constants of the IMU frame parser and filter.
`default_nettype none
package ifp_pkg;

  localparam int unsigned FrameLen = 11;

  localparam logic [7:0] HdrByte   = 8'h55;
  localparam logic [7:0] TypeAccel = 8'h51;
  localparam logic [7:0] TypeAngle = 8'h53;

  localparam int unsigned SmpW = 20;
  localparam int unsigned OpaW = 21;
  localparam int unsigned OpbW = 24;
  localparam int unsigned AccW = 42;

  // Configuration register indexes.
  localparam logic [2:0] CfgAccelScale  = 3'd0;
  localparam logic [2:0] CfgGyroScale   = 3'd1;
  localparam logic [2:0] CfgAngleScale  = 3'd2;
  localparam logic [2:0] CfgWeightNew   = 3'd3;
  localparam logic [2:0] CfgWeightMid   = 3'd4;
  localparam logic [2:0] CfgWeightOld   = 3'd5;

  localparam logic [23:0] AccelScaleRst = 24'd80281;
  localparam logic [23:0] GyroScaleRst  = 24'd1024000;
  localparam logic [23:0] AngleScaleRst = 24'd92162;
  localparam logic [15:0] WeightNewRst  = 16'd32768;
  localparam logic [15:0] WeightMidRst  = 16'd19661;
  localparam logic [15:0] WeightOldRst  = 16'd13107;

  typedef struct packed {
    logic [7:0]  frame_type;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
  } frame_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
  } mac_ctrl_t;

  typedef struct packed {
    logic signed [SmpW-1:0] newer;
    logic signed [SmpW-1:0] older;
  } hist_t;

endpackage
`default_nettype wire

[rtl/ifp_collect.sv]
// Byte collector that assembles header-aligned frames from the serial link.
`default_nettype none
module ifp_collect
  import ifp_pkg::*;
#(
  parameter int unsigned FRAME_LEN = FrameLen
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_i,
  output logic            last_o,
  output frame_t          frame_o
);

  localparam int unsigned CntW = $clog2(FRAME_LEN);

  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      bytes_q [1:FRAME_LEN-2];

  assign last_o = (count_q == CntW'(FRAME_LEN - 1));

  always_comb begin
    count_d = count_q;
    if (accept_i) begin
      if (count_q == '0) begin
        if (byte_i == HdrByte) count_d = CntW'(1);
      end else if (last_o) begin
        count_d = '0;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // The header is not stored; the checksum byte is never stored.
  always_ff @(posedge clk_i) begin
    if (accept_i && (count_q != '0) && !last_o) begin
      bytes_q[count_q] <= byte_i;
    end
  end

  assign frame_o.frame_type = bytes_q[1];
  assign frame_o.word_a     = {bytes_q[3], bytes_q[2]};
  assign frame_o.word_b     = {bytes_q[5], bytes_q[4]};
  assign frame_o.word_c     = {bytes_q[7], bytes_q[6]};
  assign frame_o.word_d     = {bytes_q[9], bytes_q[8]};

endmodule
`default_nettype wire

[rtl/ifp_mac.sv]
// Shared multiply-accumulate unit with Q16 rounding and 20-bit saturation.
`default_nettype none
`include "assert_macros.svh"
module ifp_mac
  import ifp_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mac_ctrl_t              ctrl_i,
  input  wire logic signed [OpaW-1:0] op_a_i,
  input  wire logic        [OpbW-1:0] op_b_i,
  output logic signed      [SmpW-1:0] result_o
);

  logic signed [OpaW+OpbW:0] prod;
  logic signed [AccW-1:0]    prod_q, acc_q;
  logic signed [AccW:0]      rnd;
  logic signed [AccW-16:0]   shr;

  assign prod = op_a_i * $signed({1'b0, op_b_i});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) prod_q <= prod[AccW-1:0];
    if (ctrl_i.acc_load) begin
      acc_q <= prod_q;
    end else if (ctrl_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
  end

  // Round half up, then floor by the arithmetic shift.
  assign rnd = {acc_q[AccW-1], acc_q} + (AccW+1)'(32768);
  assign shr = rnd[AccW:16];

  always_comb begin
    if (shr > (AccW-15)'(524287)) begin
      result_o = SmpW'(524287);
    end else if (shr < -(AccW-15)'(524288)) begin
      result_o = SmpW'(-524288);
    end else begin
      result_o = shr[SmpW-1:0];
    end
  end

  // The unit holds no control state; reset is observed only by the checks.
  `IFP_ASSERT(mac_one_acc_op, !(ctrl_i.acc_load && ctrl_i.acc_add))

endmodule
`default_nettype wire

[rtl/imu_frame_parser_filter_top.sv]
// Top level of the IMU frame parser with a three-tap FIR on the motion channels.
`default_nettype none
`include "assert_macros.svh"
// The block takes one received byte per transaction on the rx channel and
// assembles 11-byte frames that start with header 0x55; any other first byte
// is dropped. The checksum byte completes the frame without being checked,
// and every completed frame produces one transaction on the result channel
// carrying the type byte and four little-endian payload words. For frame
// types 0x51 (acceleration), 0x52 (gyro) and 0x53 (angle) the three axis
// words are scaled by the configured Q8.16 reciprocal and filtered by a
// three-tap FIR whose per-sensor history is cleared at reset; filtered
// values are Q.8 and saturate to 20 bits. Other types give zero filter
// fields and leave the history alone. Header and payload bytes are handled
// as they are taken, and so is the checksum byte of a non-motion frame. The
// checksum byte of a motion frame starts the sequencer, which works through
// the three axes in turn on the single shared multiplier (scale multiply,
// load, round, then three weight multiplies, a load, two accumulates and a
// round); rx_ready_o is low until it returns to idle. A pending result does
// not block payload bytes, only the next checksum byte.
// Configuration writes take effect at the next edge and must be made while
// the block is idle.
module imu_frame_parser_filter_top
  import ifp_pkg::*;
#(
  parameter int unsigned FRAME_LEN = FrameLen
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rx_valid_i,
  output logic                   rx_ready_o,
  input  wire logic [7:0]        rx_byte_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output logic [7:0]             frame_type_o,
  output logic [15:0]            word_a_o,
  output logic [15:0]            word_b_o,
  output logic [15:0]            word_c_o,
  output logic [15:0]            word_d_o,
  output logic                   filtered_valid_o,
  output logic signed [SmpW-1:0] filtered_x_o,
  output logic signed [SmpW-1:0] filtered_y_o,
  output logic signed [SmpW-1:0] filtered_z_o,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [23:0]       cfg_data_i
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SCL_MUL = 9'b000000010,
    S_SCL_ACC = 9'b000000100,
    S_SCL_RND = 9'b000001000,
    S_FIR_N   = 9'b000010000,
    S_FIR_M   = 9'b000100000,
    S_FIR_O   = 9'b001000000,
    S_FIR_ACC = 9'b010000000,
    S_FIR_RND = 9'b100000000
  } state_e;

  // Configuration registers.
  logic [23:0] accel_scale_q, gyro_scale_q, angle_scale_q;
  logic [15:0] weight_new_q, weight_mid_q, weight_old_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_scale_q <= AccelScaleRst;
      gyro_scale_q  <= GyroScaleRst;
      angle_scale_q <= AngleScaleRst;
      weight_new_q  <= WeightNewRst;
      weight_mid_q  <= WeightMidRst;
      weight_old_q  <= WeightOldRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgAccelScale: accel_scale_q <= cfg_data_i;
        CfgGyroScale:  gyro_scale_q  <= cfg_data_i;
        CfgAngleScale: angle_scale_q <= cfg_data_i;
        CfgWeightNew:  weight_new_q  <= cfg_data_i[15:0];
        CfgWeightMid:  weight_mid_q  <= cfg_data_i[15:0];
        CfgWeightOld:  weight_old_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Frame collection.
  state_e state_q, state_d;
  logic   rx_accept, coll_last, frame_done, motion;
  frame_t frame;

  // The checksum byte needs a free output register, earlier bytes do not.
  assign rx_ready_o = (state_q == S_IDLE) && (!coll_last || !res_valid_o || res_ready_i);
  assign rx_accept  = rx_valid_i && rx_ready_o;
  assign frame_done = rx_accept && coll_last;

  ifp_collect #(
    .FRAME_LEN(FRAME_LEN)
  ) u_collect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(rx_accept),
    .byte_i  (rx_byte_i),
    .last_o  (coll_last),
    .frame_o (frame)
  );

  assign motion = (frame.frame_type >= TypeAccel) && (frame.frame_type <= TypeAngle);

  // Sequencer state.
  logic [1:0]            sensor_q, sensor_d, axis_q, axis_d;
  logic signed [SmpW-1:0] s0_q, fx_q, fy_q;
  logic signed [SmpW-1:0] mac_res;
  logic [3:0]            hist_idx;
  hist_t                 hist_q [9];
  hist_t                 hist_rd;
  logic [23:0]           scale;
  logic [15:0]           raw_word;
  mac_ctrl_t             mac_ctrl;
  logic signed [OpaW-1:0] op_a;
  logic [OpbW-1:0]       op_b;
  logic                  finish;

  assign hist_idx = {1'b0, sensor_q, 1'b0} + {2'b00, sensor_q} + {2'b00, axis_q};
  assign hist_rd  = hist_q[hist_idx];

  always_comb begin
    case (sensor_q)
      2'd0:    scale = accel_scale_q;
      2'd1:    scale = gyro_scale_q;
      default: scale = angle_scale_q;
    endcase
    case (axis_q)
      2'd0:    raw_word = frame.word_a;
      2'd1:    raw_word = frame.word_b;
      default: raw_word = frame.word_c;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    sensor_d = sensor_q;
    axis_d   = axis_q;
    mac_ctrl = '0;
    op_a     = '0;
    op_b     = '0;
    finish   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (frame_done) begin
          if (motion) begin
            sensor_d = 2'(frame.frame_type - TypeAccel);
            axis_d   = 2'd0;
            state_d  = S_SCL_MUL;
          end else begin
            finish = 1'b1;
          end
        end
      end
      S_SCL_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        op_a            = OpaW'($signed(raw_word));
        op_b            = scale;
        state_d         = S_SCL_ACC;
      end
      S_SCL_ACC: begin
        mac_ctrl.acc_load = 1'b1;
        state_d           = S_SCL_RND;
      end
      S_SCL_RND: state_d = S_FIR_N;
      S_FIR_N: begin
        mac_ctrl.mul_en = 1'b1;
        op_a            = OpaW'(s0_q);
        op_b            = {8'd0, weight_new_q};
        state_d         = S_FIR_M;
      end
      S_FIR_M: begin
        mac_ctrl.mul_en   = 1'b1;
        mac_ctrl.acc_load = 1'b1;
        op_a              = OpaW'(hist_rd.newer);
        op_b              = {8'd0, weight_mid_q};
        state_d           = S_FIR_O;
      end
      S_FIR_O: begin
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.acc_add = 1'b1;
        op_a             = OpaW'(hist_rd.older);
        op_b             = {8'd0, weight_old_q};
        state_d          = S_FIR_ACC;
      end
      S_FIR_ACC: begin
        mac_ctrl.acc_add = 1'b1;
        state_d          = S_FIR_RND;
      end
      S_FIR_RND: begin
        if (axis_q == 2'd2) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = S_SCL_MUL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  ifp_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .op_a_i  (op_a),
    .op_b_i  (op_b),
    .result_o(mac_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sensor_q <= 2'd0;
      axis_q   <= 2'd0;
    end else begin
      state_q  <= state_d;
      sensor_q <= sensor_d;
      axis_q   <= axis_d;
    end
  end

  // History: the newer tap takes the new scaled sample, the older tap the old newer one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) hist_q[i] <= '0;
    end else if (state_q == S_FIR_RND) begin
      hist_q[hist_idx] <= '{newer: s0_q, older: hist_rd.newer};
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SCL_RND) s0_q <= mac_res;
    if (state_q == S_FIR_RND && axis_q == 2'd0) fx_q <= mac_res;
    if (state_q == S_FIR_RND && axis_q == 2'd1) fy_q <= mac_res;
  end

  // Output register.
  logic res_valid_q;
  assign res_valid_o = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (finish) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      frame_type_o     <= frame.frame_type;
      word_a_o         <= frame.word_a;
      word_b_o         <= frame.word_b;
      word_c_o         <= frame.word_c;
      word_d_o         <= frame.word_d;
      filtered_valid_o <= (state_q == S_FIR_RND);
      filtered_x_o     <= (state_q == S_FIR_RND) ? fx_q : '0;
      filtered_y_o     <= (state_q == S_FIR_RND) ? fy_q : '0;
      filtered_z_o     <= (state_q == S_FIR_RND) ? mac_res : '0;
    end
  end

  // A motion frame only starts when the output register is free, so nothing
  // is pending by the time its result is written.
  `IFP_ASSERT(no_result_overwrite, (state_q == S_FIR_RND) |-> !res_valid_q)
  `IFP_ASSERT(busy_not_ready, (state_q != S_IDLE) |-> !rx_ready_o)
  `IFP_ASSERT(unfiltered_zero,
    (res_valid_o && !filtered_valid_o) |->
    (filtered_x_o == '0 && filtered_y_o == '0 && filtered_z_o == '0))
  `IFP_ASSERT(axis_in_range, (state_q != S_IDLE) |-> (axis_q != 2'd3 && sensor_q != 2'd3))

endmodule
`default_nettype wire

[tb/sv/imu_frame_parser_filter_top_test.sv]
// Self-checking testbench of the IMU frame parser with its three-tap motion filter.
module imu_frame_parser_filter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ifp_pkg::*;

  // Frame types that the package does not name.
  localparam logic [7:0] TypeTime = 8'h50;
  localparam logic [7:0] TypeGyro = 8'h52;
  localparam logic [7:0] TypeMag  = 8'h54;
  localparam logic [7:0] TypeGps  = 8'h58;

  // Register indexes past the end of the list; writes to them must be dropped.
  localparam logic [2:0] CfgUnusedLo = 3'd6;
  localparam logic [2:0] CfgUnusedHi = 3'd7;
  localparam logic [2:0] RegIdx [6] = '{CfgAccelScale, CfgGyroScale, CfgAngleScale,
                                         CfgWeightNew, CfgWeightMid, CfgWeightOld};

  localparam longint SatMax = 524287;
  localparam longint SatMin = -524288;

  // The checksum byte of a motion frame keeps the block busy while the sequencer runs.
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned PhaseBytes   = 33;
  localparam longint      TimeoutNs    = 2_000_000;

  // One result transaction as the block presents it.
  typedef struct packed {
    logic [7:0]  frame_type;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
    logic        filt_valid;
    logic [19:0] filt_x;
    logic [19:0] filt_y;
    logic [19:0] filt_z;
  } frame_result_t;

  // One row of the directed table. A row may carry one stray byte that goes
  // out ahead of its header. Where typed is set, the expected result is the
  // row's own type and words with the given filter flag and all filter
  // outputs zero; other rows go through the predictor.
  typedef struct packed {
    logic        has_junk;
    logic [7:0]  junk;
    logic [7:0]  ftype;
    logic [15:0] wa;
    logic [15:0] wb;
    logic [15:0] wc;
    logic [15:0] wd;
    logic [7:0]  cks;
    logic        typed;
    logic        fv;
  } dir_row_t;

  localparam int unsigned NumRows = 19;
  localparam dir_row_t DirRows [NumRows] = '{
    // Motion frames with zero words right after reset: history is clear, so
    // every filter output is zero. Stray bytes ahead of two of them.
    '{1'b0, 8'h00, TypeAccel, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1},
    '{1'b1, 8'h00, TypeGyro,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'hFF, 1'b1, 1'b1},
    '{1'b1, 8'hFF, TypeAngle, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'hA5, 1'b1, 1'b1},
    // Non-motion and unknown types only echo their words.
    '{1'b0, 8'h00, TypeTime,  16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 8'h00, 1'b1, 1'b0},
    '{1'b1, 8'hAA, TypeMag,   16'h5555, 16'h55AA, 16'h0055, 16'hFFFF, 8'h55, 1'b1, 1'b0},
    '{1'b0, 8'h00, TypeGps,   16'h1234, 16'hABCD, 16'h8001, 16'h7FFE, 8'hFF, 1'b1, 1'b0},
    '{1'b1, 8'h54, 8'h00,     16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 8'h12, 1'b1, 1'b0},
    '{1'b0, 8'h00, 8'hFF,     16'h0001, 16'h8000, 16'h0100, 16'h00FF, 8'h34, 1'b1, 1'b0},
    '{1'b0, 8'h00, HdrByte,   16'h5555, 16'h5555, 16'h5555, 16'h5555, 8'h55, 1'b1, 1'b0},
    // Axis extremes run through the predictor while the history fills up.
    '{1'b0, 8'h00, TypeAccel, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h1234, 8'h00, 1'b0, 1'b0},
    '{1'b0, 8'h00, TypeAccel, 16'h8000, 16'h7FFF, 16'h0001, 16'h0000, 8'h00, 1'b0, 1'b0},
    '{1'b0, 8'h00, TypeAccel, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 8'h00, 1'b0, 1'b0},
    '{1'b0, 8'h00, TypeGyro,  16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 8'h00, 1'b0, 1'b0},
    '{1'b0, 8'h00, TypeGyro,  16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 8'h00, 1'b0, 1'b0},
    // A non-motion frame in between must leave the gyro history alone.
    '{1'b0, 8'h00, TypeGps,   16'hC3C3, 16'h3C3C, 16'h0F0F, 16'hF0F0, 8'h00, 1'b1, 1'b0},
    '{1'b0, 8'h00, TypeGyro,  16'h0001, 16'hFFFF, 16'h4000, 16'hC000, 8'h00, 1'b0, 1'b0},
    '{1'b0, 8'h00, TypeAngle, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h00, 1'b0, 1'b0},
    '{1'b0, 8'h00, TypeAngle, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'hFF, 1'b0, 1'b0},
    '{1'b0, 8'h00, TypeAccel, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 8'h00, 1'b0, 1'b0}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        rx_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        res_ready_i = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_index_i = CfgAccelScale;
  logic [23:0] cfg_data_i  = 24'h000000;

  logic                   rx_ready_o;
  logic                   res_valid_o;
  logic [7:0]             frame_type_o;
  logic [15:0]            word_a_o;
  logic [15:0]            word_b_o;
  logic [15:0]            word_c_o;
  logic [15:0]            word_d_o;
  logic                   filtered_valid_o;
  logic signed [SmpW-1:0] filtered_x_o;
  logic signed [SmpW-1:0] filtered_y_o;
  logic signed [SmpW-1:0] filtered_z_o;

  imu_frame_parser_filter_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_valid_i),
    .rx_ready_o       (rx_ready_o),
    .rx_byte_i        (rx_byte_i),
    .res_valid_o      (res_valid_o),
    .res_ready_i      (res_ready_i),
    .frame_type_o     (frame_type_o),
    .word_a_o         (word_a_o),
    .word_b_o         (word_b_o),
    .word_c_o         (word_c_o),
    .word_d_o         (word_d_o),
    .filtered_valid_o (filtered_valid_o),
    .filtered_x_o     (filtered_x_o),
    .filtered_y_o     (filtered_y_o),
    .filtered_z_o     (filtered_z_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Predictor state: our own copy of the registers, the frame being
  // collected and the per-sensor filter history (sensor x axis).
  // ---------------------------------------------------------------------
  logic [23:0] scale_q [3];
  logic [15:0] wt_new;
  logic [15:0] wt_mid;
  logic [15:0] wt_old;
  logic [7:0]  frame_buf [10];
  int unsigned fill_cnt;
  hist_t       sensor_hist [3][3];

  frame_result_t expected_frames [$];
  int unsigned   err_count;
  int unsigned   used_bytes;     // accepted bytes that the parser did not drop
  int unsigned   snd_idle_pct;   // chance per cycle that the sender holds off
  int unsigned   rcv_stall_pct;  // chance per cycle that the receiver stalls

  // Directed rows with a typed expectation put it in place of the predicted one.
  bit            override_on;
  frame_result_t override_res;

  function automatic void reset_model();
    scale_q[0] = AccelScaleRst;
    scale_q[1] = GyroScaleRst;
    scale_q[2] = AngleScaleRst;
    wt_new     = WeightNewRst;
    wt_mid     = WeightMidRst;
    wt_old     = WeightOldRst;
    fill_cnt   = 0;
    for (int s = 0; s < 3; s++) begin
      for (int a = 0; a < 3; a++) begin
        sensor_hist[s][a] = '0;
      end
    end
  endfunction

  // Bits above a register's width are dropped, and so are unknown indexes.
  function automatic void store_reg(input logic [2:0] idx, input logic [23:0] data);
    case (idx)
      CfgAccelScale: scale_q[0] = data;
      CfgGyroScale:  scale_q[1] = data;
      CfgAngleScale: scale_q[2] = data;
      CfgWeightNew:  wt_new = data[15:0];
      CfgWeightMid:  wt_mid = data[15:0];
      CfgWeightOld:  wt_old = data[15:0];
      default: ;
    endcase
  endfunction

  // Divide by 2^16 rounding half up; the arithmetic shift floors.
  function automatic longint round_q16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic [19:0] clamp_q8(input longint v);
    if (v > SatMax) return 20'(SatMax);
    if (v < SatMin) return 20'(SatMin);
    return 20'(v);
  endfunction

  // Scale one axis word to Q.8, run it through the FIR and shift the history.
  function automatic logic [19:0] fir_axis(input int sensor, input int axis,
                                           input logic [15:0] word);
    longint raw;
    longint prod;
    longint acc;
    logic signed [19:0] s0;
    logic signed [19:0] s1;
    logic signed [19:0] s2;
    raw  = longint'($signed(word));
    prod = raw * longint'(scale_q[sensor]);
    s0   = clamp_q8(round_q16(prod));
    s1   = sensor_hist[sensor][axis].newer;
    s2   = sensor_hist[sensor][axis].older;
    acc  = longint'(wt_new) * longint'(s0) + longint'(wt_mid) * longint'(s1)
         + longint'(wt_old) * longint'(s2);
    sensor_hist[sensor][axis].older = s1;
    sensor_hist[sensor][axis].newer = s0;
    return clamp_q8(round_q16(acc));
  endfunction

  // Feed one accepted byte to the frame collector. Returns 1 when the byte
  // completes a frame, with the result the block must produce for it.
  function automatic bit take_rx_byte(input logic [7:0] b, output frame_result_t res,
                                      output bit dropped);
    logic [15:0] words [4];
    int sensor;
    res     = '0;
    dropped = 1'b0;
    if (fill_cnt == 0) begin
      if (b != HdrByte) begin
        dropped = 1'b1;
      end else begin
        frame_buf[0] = b;
        fill_cnt = 1;
      end
      return 1'b0;
    end
    if (fill_cnt < FrameLen - 1) begin
      frame_buf[fill_cnt] = b;
      fill_cnt++;
      return 1'b0;
    end
    // The checksum byte closes the frame and is never looked at.
    fill_cnt = 0;
    for (int i = 0; i < 4; i++) begin
      words[i] = {frame_buf[3 + 2 * i], frame_buf[2 + 2 * i]};
    end
    res.frame_type = frame_buf[1];
    res.word_a     = words[0];
    res.word_b     = words[1];
    res.word_c     = words[2];
    res.word_d     = words[3];
    if (frame_buf[1] >= TypeAccel && frame_buf[1] <= TypeAngle) begin
      sensor         = int'(frame_buf[1] - TypeAccel);
      res.filt_valid = 1'b1;
      res.filt_x     = fir_axis(sensor, 0, words[0]);
      res.filt_y     = fir_axis(sensor, 1, words[1]);
      res.filt_z     = fir_axis(sensor, 2, words[2]);
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------
  task automatic report_error(input string msg);
    $display("%0t ns: ERROR: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [23:0] got,
                             input logic [23:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  // Every result transaction is matched against the oldest expected frame.
  always @(posedge clk_i) begin : res_monitor
    frame_result_t want;
    if (rst_ni && res_valid_o && res_ready_i) begin
      if (expected_frames.size() == 0) begin
        report_error($sformatf("result with no frame pending, type %h", frame_type_o));
      end else begin
        want = expected_frames.pop_front();
        check_field("frame_type", frame_type_o, want.frame_type);
        check_field("word_a", word_a_o, want.word_a);
        check_field("word_b", word_b_o, want.word_b);
        check_field("word_c", word_c_o, want.word_c);
        check_field("word_d", word_d_o, want.word_d);
        check_field("filtered_valid", filtered_valid_o, want.filt_valid);
        check_field("filtered_x", filtered_x_o[19:0], want.filt_x);
        check_field("filtered_y", filtered_y_o[19:0], want.filt_y);
        check_field("filtered_z", filtered_z_o[19:0], want.filt_z);
      end
    end
  end

  // The receiver stalls at random with the chance the current phase sets.
  always @(negedge clk_i) begin
    res_ready_i <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers. Every task is entered and left just after a falling
  // edge, so inputs only ever change there.
  // ---------------------------------------------------------------------

  // Offer one byte as an rx transaction and wait for it to be taken. Valid
  // stays high into the next byte unless the sender decides to idle.
  task automatic send_byte(input logic [7:0] b);
    frame_result_t res;
    bit dropped;
    while ($urandom_range(99) < snd_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!rx_ready_o) @(posedge clk_i);
    if (take_rx_byte(b, res, dropped)) begin
      expected_frames.push_back(override_on ? override_res : res);
    end
    if (!dropped) used_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] wa,
                            input logic [15:0] wb, input logic [15:0] wc,
                            input logic [15:0] wd, input logic [7:0] cks);
    send_byte(HdrByte);
    send_byte(ftype);
    send_byte(wa[7:0]);
    send_byte(wa[15:8]);
    send_byte(wb[7:0]);
    send_byte(wb[15:8]);
    send_byte(wc[7:0]);
    send_byte(wc[15:8]);
    send_byte(wd[7:0]);
    send_byte(wd[15:8]);
    send_byte(cks);
  endtask

  // Hold the sender off until every result that is owed has arrived.
  task automatic drain_results();
    rx_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Bring the block to rest: close any partial frame, collect all results and
  // give the sequencer time to wind down before registers are touched.
  task automatic settle_idle();
    while (fill_cnt != 0) send_byte(8'($urandom()));
    rx_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Program all six registers for one phase. Write enable stays high across
  // the whole burst, which is bracketed by writes to unused indexes.
  task automatic load_settings(input int unsigned setting);
    logic [23:0] vals [6];
    logic [23:0] stray;
    vals[0] = AccelScaleRst;
    vals[1] = GyroScaleRst;
    vals[2] = AngleScaleRst;
    vals[3] = {8'h00, WeightNewRst};
    vals[4] = {8'h00, WeightMidRst};
    vals[5] = {8'h00, WeightOldRst};
    case (setting)
      1: begin
        for (int i = 0; i < 6; i++) vals[i] = 24'hFFFFFF;
      end
      2: begin
        for (int i = 0; i < 6; i++) vals[i] = 24'h000000;
      end
      3: begin
        // Unity scale and weights that sum to one.
        for (int i = 0; i < 3; i++) vals[i] = 24'h010000;
        vals[3] = 24'h008000;
        vals[4] = 24'h004000;
        vals[5] = 24'h004000;
      end
      0: ;
      default: begin
        for (int i = 0; i < 6; i++) vals[i] = 24'($urandom());
      end
    endcase
    // Garbage above the 16 bits of a weight must not reach the register.
    for (int i = 3; i < 6; i++) vals[i][23:16] = 8'($urandom());

    stray = 24'($urandom());
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgUnusedLo;
    cfg_data_i  <= stray;
    store_reg(CfgUnusedLo, stray);
    @(negedge clk_i);
    for (int i = 0; i < 6; i++) begin
      cfg_index_i <= RegIdx[i];
      cfg_data_i  <= vals[i];
      store_reg(RegIdx[i], vals[i]);
      @(negedge clk_i);
    end
    stray = 24'($urandom());
    cfg_index_i <= CfgUnusedHi;
    cfg_data_i  <= stray;
    store_reg(CfgUnusedHi, stray);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Axis words lean toward the extremes and toward small values around zero.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      4: return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence: reset, the directed table, then one random phase per
  // register setting, with idling patterns that repeat every four phases.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t    row;
    logic [7:0]  ftype;
    int unsigned roll;
    err_count     = 0;
    used_bytes    = 0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    override_on   = 1'b0;
    override_res  = '0;
    reset_model();

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table, back to back with the reset register values.
    for (int r = 0; r < NumRows; r++) begin
      row          = DirRows[r];
      override_on  = row.typed;
      override_res = '{frame_type: row.ftype, word_a: row.wa, word_b: row.wb,
                       word_c: row.wc, word_d: row.wd, filt_valid: row.fv,
                       filt_x: '0, filt_y: '0, filt_z: '0};
      if (row.has_junk) send_byte(row.junk);
      send_frame(row.ftype, row.wa, row.wb, row.wc, row.wd, row.cks);
    end
    override_on = 1'b0;

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      settle_idle();
      load_settings(ph);
      case (ph % 4)
        0: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
        end
        1: begin
          snd_idle_pct  = 64;
          rcv_stall_pct = 0;
        end
        2: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 64;
        end
        default: begin
          snd_idle_pct  = 22;
          rcv_stall_pct = 22;
        end
      endcase
      used_bytes = 0;
      while (used_bytes < PhaseBytes) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          // Line noise; a stray header byte here knocks the next frame out
          // of step, which the collector has to ride out.
          send_byte(8'($urandom()));
        end else begin
          if ($urandom_range(99) < 75) begin
            ftype = 8'(TypeAccel + $urandom_range(2));
          end else begin
            ftype = 8'($urandom());
          end
          send_frame(ftype, pick_word(), pick_word(), pick_word(), pick_word(),
                     8'($urandom()));
        end
        if ($urandom_range(15) == 0) drain_results();
      end
    end

    settle_idle();
    if (err_count == 0) begin
      $display("imu_frame_parser_filter_top_test: PASS");
    end else begin
      $display("imu_frame_parser_filter_top_test: FAIL");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin : watchdog
    #(TimeoutNs);
    $display("imu_frame_parser_filter_top_test: FAIL");
    $finish;
  end

endmodule
